[rtl/ope_pkg.sv]
// Ogg page packet extractor: shared types and constants.
// Phase and status codes, header byte positions, result layout.
// No dependencies.
package ope_pkg;

  localparam int HeaderBytes = 27;
  localparam int TableDepth  = 256;
  localparam int TableAw     = $clog2(TableDepth);

  localparam logic [7:0]  EosMask   = 8'h04;
  localparam logic [7:0]  LaceFull  = 8'hFF;

  localparam logic [4:0] HdrMagicEnd = 5'd4;
  localparam logic [4:0] HdrEosByte  = 5'd5;
  localparam logic [4:0] HdrLast     = 5'(HeaderBytes - 1);

  typedef enum logic [1:0] {
    PhHeader,
    PhLacing,
    PhData
  } phase_e;

  typedef enum logic [2:0] {
    StData    = 3'd0,
    StCapture = 3'd1,
    StZero    = 3'd2,
    StLarge   = 3'd3,
    StTrunc   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        packet_end;
    logic [15:0] packet_length;
    logic        stream_done;
    status_e     status;
  } result_t;

  // "OggS"
  function automatic logic [7:0] capture_byte(input logic [1:0] pos);
    logic [7:0] val;
    unique case (pos)
      2'd0:    val = 8'h4F;
      2'd1:    val = 8'h67;
      2'd2:    val = 8'h67;
      default: val = 8'h53;
    endcase
    return val;
  endfunction

endpackage

[rtl/ope_ram.sv]
// Ogg page packet extractor: generic single-write, single-read RAM.
// Registered read, old data on a same-address read and write.
// No dependencies.
module ope_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/ogg_page_packet_extractor.sv]
// Ogg page packet extractor: top level.
// Depends on ope_pkg and ope_ram (lacing table).
//
// Usage:
//   Slave stream: one Ogg stream byte per transaction in s_axis_tdata_i;
//   s_axis_tuser_i high marks end of input (no byte carried).
//   Master stream: zero or one result per input transaction.
//     tdata = payload byte, packet length; tlast = last byte of a packet;
//     tuser = stream done, status (0 data, else an error code).
//   MaxPacket sets the longest packet in bytes.
//   Throughput: one byte per cycle unless the receiver stalls. Each byte
//   makes one lacing table access; the table read address is taken from
//   the next-state value so the registered read already matches the
//   segment in use. A result is written into the output register as its
//   byte is accepted.
//   The output register lets a new byte in whenever it is empty or is
//   being drained; while the receiver stalls with a result held,
//   s_axis_tready_o is low.
//   Reset: empties the output register and returns to header collection.
//   The lacing table needs no clearing; entries are read only once written.
//   After an error or the end-of-stream packet, bytes are still taken
//   but give no results until reset.
module ogg_page_packet_extractor
  import ope_pkg::*;
#(
  parameter int unsigned MaxPacket = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] input_ended
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] payload_byte, [23:8] packet_length
  output logic        m_axis_tlast_o,   // packet_end
  output logic [3:0]  m_axis_tuser_o    // [0] stream_done, [3:1] status
);

  localparam logic [15:0] MaxLen = 16'(MaxPacket);

  phase_e      phase_q, phase_d;
  logic [4:0]  hdr_cnt_q, hdr_cnt_d;
  logic        cap_q, cap_d;
  logic        eos_q, eos_d;
  logic [7:0]  segs_q, segs_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  left_q, left_d;
  logic        full_q, full_d;
  logic [15:0] len_q, len_d;
  logic        halted_q, halted_d;
  logic [7:0]  first_q, first_d;

  logic        byp_q, byp_d;
  logic [7:0]  byp_data_q;
  logic [7:0]  ram_rdata;
  logic [7:0]  lace_rd;
  logic        ram_we;

  logic        in_acc;
  logic        res_valid;
  result_t     res;
  logic        m_valid_q, m_valid_d;
  result_t     m_res_q;

  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign s_axis_tready_o = ~m_valid_q | m_axis_tready_i;
  assign lace_rd         = byp_q ? byp_data_q : ram_rdata;
  assign byp_d           = ram_we && (idx_q == idx_d);

  ope_ram #(
    .Width (8),
    .Depth (TableDepth)
  ) u_lacing (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q[TableAw-1:0]),
    .wdata_i (s_axis_tdata_i),
    .raddr_i (idx_d[TableAw-1:0]),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    logic [4:0]  hc;
    logic        cap;
    logic        hdr_path;
    logic        err;
    logic [7:0]  left;
    logic        full;
    logic [7:0]  t0;
    logic        end_f;
    logic [15:0] len;

    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    cap_d     = cap_q;
    eos_d     = eos_q;
    segs_d    = segs_q;
    idx_d     = idx_q;
    left_d    = left_q;
    full_d    = full_q;
    len_d     = len_q;
    halted_d  = halted_q;
    first_d   = first_q;
    ram_we    = 1'b0;
    res_valid = 1'b0;
    res       = '0;
    res.status = StData;
    hc        = hdr_cnt_q;
    cap       = cap_q;
    hdr_path  = 1'b0;
    err       = 1'b0;
    left      = left_q;
    full      = full_q;
    t0        = first_q;
    end_f     = 1'b0;
    len       = len_q;

    if (in_acc && !halted_q) begin
      if (s_axis_tuser_i) begin
        res_valid  = 1'b1;
        res.status = StTrunc;
        halted_d   = 1'b1;
      end else begin
        unique case (phase_q)
          PhHeader: hdr_path = 1'b1;
          PhLacing: begin
            ram_we = 1'b1;
            if (idx_q == 8'd0) begin
              first_d = s_axis_tdata_i;
            end
            if (({1'b0, idx_q} + 9'd1) < {1'b0, segs_q}) begin
              idx_d = idx_q + 8'd1;
            end else begin
              phase_d = PhData;
              idx_d   = 8'd0;
              left_d  = 8'd0;
              t0      = (idx_q == 8'd0) ? s_axis_tdata_i : first_q;
              if (t0 == 8'd0) begin
                idx_d = 8'd1;
                res_valid = 1'b1;
                if (len_q == 16'd0) begin
                  res.status = StZero;
                  halted_d   = 1'b1;
                end else begin
                  res.packet_end    = 1'b1;
                  res.packet_length = len_q;
                  res.stream_done   = eos_q && (segs_q == 8'd1);
                  len_d    = 16'd0;
                  halted_d = eos_q && (segs_q == 8'd1);
                end
              end
            end
          end
          PhData: begin
            if (left_q == 8'd0) begin
              if (idx_q >= segs_q) begin
                hdr_path = 1'b1;
                hc       = 5'd0;
                cap      = 1'b1;
              end else begin
                idx_d = idx_q + 8'd1;
                if (lace_rd == 8'd0) begin
                  err        = 1'b1;
                  res_valid  = 1'b1;
                  res.status = StZero;
                  halted_d   = 1'b1;
                end else begin
                  left = lace_rd;
                  full = (lace_rd == LaceFull);
                end
              end
            end
            if (!hdr_path && !err) begin
              res_valid = 1'b1;
              if (len_q >= MaxLen) begin
                res.status = StLarge;
                halted_d   = 1'b1;
              end else begin
                len  = len_q + 16'd1;
                left = left - 8'd1;
                if (left == 8'd0) begin
                  if (!full) begin
                    end_f = 1'b1;
                  end else if (idx_q < segs_q && lace_rd == 8'd0) begin
                    idx_d = idx_q + 8'd1;
                    end_f = 1'b1;
                  end
                end
                left_d = left;
                full_d = full;
                len_d  = len;
                res.payload_byte  = s_axis_tdata_i;
                res.packet_length = len;
                res.packet_end    = end_f;
                if (end_f) begin
                  res.stream_done = eos_q && (idx_d == segs_q);
                  halted_d        = eos_q && (idx_d == segs_q);
                  len_d           = 16'd0;
                end
              end
            end
          end
          default: ;
        endcase

        if (hdr_path) begin
          if (hc < HdrMagicEnd && s_axis_tdata_i != capture_byte(hc[1:0])) begin
            cap = 1'b0;
          end
          if (hc == HdrEosByte) begin
            eos_d = (s_axis_tdata_i & EosMask) != 8'd0;
          end
          phase_d = PhHeader;
          if (hc == HdrLast) begin
            hdr_cnt_d = 5'd0;
            cap_d     = 1'b1;
            segs_d    = s_axis_tdata_i;
            if (!cap) begin
              res_valid  = 1'b1;
              res.status = StCapture;
              halted_d   = 1'b1;
            end else if (s_axis_tdata_i != 8'd0) begin
              phase_d = PhLacing;
              idx_d   = 8'd0;
            end
          end else begin
            hdr_cnt_d = hc + 5'd1;
            cap_d     = cap;
          end
        end
      end
    end
  end

  // output register next state
  always_comb begin
    if (in_acc) begin
      m_valid_d = res_valid;
    end else begin
      m_valid_d = m_valid_q & ~m_axis_tready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      hdr_cnt_q <= 5'd0;
      cap_q     <= 1'b1;
      eos_q     <= 1'b0;
      segs_q    <= 8'd0;
      idx_q     <= 8'd0;
      left_q    <= 8'd0;
      full_q    <= 1'b0;
      len_q     <= 16'd0;
      halted_q  <= 1'b0;
      byp_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      cap_q     <= cap_d;
      eos_q     <= eos_d;
      segs_q    <= segs_d;
      idx_q     <= idx_d;
      left_q    <= left_d;
      full_q    <= full_d;
      len_q     <= len_d;
      halted_q  <= halted_d;
      byp_q     <= byp_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= first_d;
    byp_data_q <= s_axis_tdata_i;
    if (in_acc && res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_res_q.packet_length, m_res_q.payload_byte};
  assign m_axis_tlast_o  = m_res_q.packet_end;
  assign m_axis_tuser_o  = {m_res_q.status, m_res_q.stream_done};

  // no result once halted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_valid)
    else $error("result produced while halted");

  // an error result halts the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid && res.status != StData) |=> halted_q)
    else $error("error result without halt");

  // data results never carry a zero length, the end marker path included
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res_valid && res.status == StData) |-> res.packet_length != 16'd0)
    else $error("data result with zero length");

  // segment index stays inside the page in data phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (idx_q <= segs_q))
    else $error("segment index past page end");

endmodule

[tb/sv/ogg_page_packet_extractor_checker.sv]
`timescale 1ns / 100ps
// Checker for the Ogg page packet extractor: watches both stream channels,
// predicts each result from the accepted bytes and compares it field by field.
// Depends on ope_pkg for the result layout and the status and phase codes.
module ogg_page_packet_extractor_checker
  import ope_pkg::*;
#(
  parameter int unsigned MaxPacket = 65535
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] input_ended
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [23:0] m_axis_tdata_i,   // [7:0] payload_byte, [23:8] packet_length
  input  logic        m_axis_tlast_i,   // packet_end
  input  logic [3:0]  m_axis_tuser_i,   // [0] stream_done, [3:1] status
  output int          mismatches_o,
  output int          pending_o,
  output int          checked_o,
  output int          packets_o
);

  localparam logic [31:0] OggMagic = 32'h5367_674F;  // "OggS", first byte lowest

  phase_e      ph;
  logic [4:0]  hdr_cnt;
  logic        magic_ok;
  logic        eos_page;
  logic [7:0]  seg_total;
  logic [7:0]  lace_mem [TableDepth];
  logic [7:0]  seg_idx;
  logic [7:0]  seg_left;
  logic [15:0] pkt_len;
  logic        stopped;

  result_t     expected_q [$];
  result_t     want;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    mismatches_o++;
  endtask

  task automatic push_result(input logic [7:0] b, input logic fin, input logic [15:0] len,
                             input logic done, input status_e st);
    result_t r;
    r.payload_byte  = b;
    r.packet_end    = fin;
    r.packet_length = len;
    r.stream_done   = done;
    r.status        = st;
    expected_q.push_back(r);
    // errors and the end-of-stream packet both stop the block
    if (st != StData || done) stopped = 1'b1;
  endtask

  task automatic restart_header();
    ph       = PhHeader;
    hdr_cnt  = '0;
    magic_ok = 1'b1;
  endtask

  task automatic take_header(input logic [7:0] b);
    if (hdr_cnt < HdrMagicEnd && b != OggMagic[hdr_cnt[1:0] * 8 +: 8]) magic_ok = 1'b0;
    if (hdr_cnt == HdrEosByte) eos_page = (b & EosMask) != 8'h00;
    if (hdr_cnt == HdrLast) seg_total = b;
    hdr_cnt++;
    if (hdr_cnt < HeaderBytes) return;
    hdr_cnt = '0;
    if (!magic_ok) begin
      push_result(8'h00, 1'b0, 16'h0000, 1'b0, StCapture);
      return;
    end
    // empty page: skipped, an open packet stays open
    if (seg_total == 8'd0) begin
      restart_header();
      return;
    end
    ph      = PhLacing;
    seg_idx = '0;
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic ended);
    logic [7:0]  lace;
    logic [15:0] len;
    logic        fin;
    logic        done;
    if (stopped) return;
    if (ended) begin
      push_result(8'h00, 1'b0, 16'h0000, 1'b0, StTrunc);
      return;
    end
    case (ph)
      PhHeader: begin
        take_header(b);
      end
      PhLacing: begin
        lace_mem[seg_idx] = b;
        seg_idx++;
        if (seg_idx < seg_total) return;
        ph       = PhData;
        seg_idx  = '0;
        seg_left = '0;
        if (lace_mem[0] != 8'd0) return;
        // leading zero closes the packet carried over from the last page
        seg_idx = 8'd1;
        if (pkt_len == 16'd0) begin
          push_result(8'h00, 1'b0, 16'h0000, 1'b0, StZero);
          return;
        end
        len     = pkt_len;
        pkt_len = '0;
        done    = eos_page && seg_idx == seg_total;
        push_result(8'h00, 1'b1, len, done, StData);
      end
      default: begin
        while (seg_left == 8'd0) begin
          if (seg_idx >= seg_total) begin
            restart_header();
            take_header(b);
            return;
          end
          lace = lace_mem[seg_idx];
          seg_idx++;
          if (lace == 8'd0) begin
            push_result(8'h00, 1'b0, 16'h0000, 1'b0, StZero);
            return;
          end
          seg_left = lace;
        end
        if ({16'd0, pkt_len} >= MaxPacket) begin
          push_result(8'h00, 1'b0, 16'h0000, 1'b0, StLarge);
          return;
        end
        pkt_len++;
        seg_left--;
        len  = pkt_len;
        fin  = 1'b0;
        done = 1'b0;
        if (seg_left == 8'd0) begin
          if (lace_mem[seg_idx - 8'd1] != LaceFull) begin
            fin = 1'b1;
          end else if (seg_idx < seg_total && lace_mem[seg_idx] == 8'd0) begin
            // full segment followed by a zero on the same page
            seg_idx++;
            fin = 1'b1;
          end
        end
        if (fin) begin
          done    = eos_page && seg_idx == seg_total;
          pkt_len = '0;
        end
        push_result(b, fin, len, done, StData);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_header();
      eos_page  = 1'b0;
      seg_total = '0;
      seg_idx   = '0;
      seg_left  = '0;
      pkt_len   = '0;
      stopped   = 1'b0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_byte(s_axis_tdata_i, s_axis_tuser_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected, status",
                          m_axis_tuser_i[3:1], 0);
        end else begin
          want = expected_q.pop_front();
          if (m_axis_tdata_i[7:0] !== want.payload_byte)
            report_mismatch("payload_byte", m_axis_tdata_i[7:0], want.payload_byte);
          if (m_axis_tdata_i[23:8] !== want.packet_length)
            report_mismatch("packet_length", m_axis_tdata_i[23:8], want.packet_length);
          if (m_axis_tlast_i !== want.packet_end)
            report_mismatch("packet_end", m_axis_tlast_i, want.packet_end);
          if (m_axis_tuser_i[0] !== want.stream_done)
            report_mismatch("stream_done", m_axis_tuser_i[0], want.stream_done);
          if (m_axis_tuser_i[3:1] !== want.status)
            report_mismatch("status", m_axis_tuser_i[3:1], want.status);
          checked_o++;
          if (want.packet_end) packets_o++;
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

[tb/sv/ogg_page_packet_extractor_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the Ogg page packet extractor: builds an Ogg byte stream of
// directed and random pages, drives it with random gaps and back-pressure.
// Depends on ope_pkg, the block and ogg_page_packet_extractor_checker.
module ogg_page_packet_extractor_tb;
  import ope_pkg::*;

  localparam int          ItemCount  = 1400;
  localparam int          CycleLimit = 1000000;
  localparam int          HoldAt     = 400;
  localparam int          HoldLen    = 300;
  localparam int          QuietFrom  = 1500;
  localparam int          QuietTo    = 2500;
  localparam int          DrainWait  = 32;
  localparam int          MaxPkt     = 300;
  localparam int          LargeBytes = 540;
  localparam logic [31:0] OggMagic   = 32'h5367_674F;

  localparam int EndDone    = 0;
  localparam int EndCapture = 1;
  localparam int EndZero    = 2;
  localparam int EndLarge   = 3;
  localparam int EndTrunc   = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i;
  logic        s_axis_tuser_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [3:0]  m_axis_tuser_o;

  int mismatches;
  int pending;
  int checked;
  int packets;
  int cyc;

  logic [8:0] byte_q [$];     // {input_ended, data_byte}
  int         lace_plan [$];
  logic       pkt_open;
  int         open_len;
  int         page_cnt;

  ogg_page_packet_extractor #(
    .MaxPacket (MaxPkt)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  ogg_page_packet_extractor_checker #(
    .MaxPacket (MaxPkt)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .checked_o       (checked),
    .packets_o       (packets)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic logic idle_now();
    return (cyc < QuietFrom || cyc >= QuietTo) && $urandom_range(99) < 6;
  endfunction

  // Header, lacing table from lace_plan, then random data bytes.
  task automatic put_page(input logic eos, input int bad_pos);
    logic [7:0] hb;
    int         total;
    total = 0;
    for (int i = 0; i < HeaderBytes; i++) begin
      hb = 8'($urandom);
      if (i < 4) hb = OggMagic[i * 8 +: 8];
      if (i == bad_pos) hb = hb ^ 8'($urandom_range(255, 1));
      if (i == HdrEosByte) hb = eos ? (hb | EosMask) : (hb & ~EosMask);
      if (i == HdrLast) hb = 8'(lace_plan.size());
      byte_q.push_back({1'b0, hb});
    end
    foreach (lace_plan[i]) begin
      byte_q.push_back({1'b0, 8'(lace_plan[i])});
      total += lace_plan[i];
      open_len = (lace_plan[i] == LaceFull) ? open_len + lace_plan[i] : 0;
    end
    repeat (total) byte_q.push_back({1'b0, 8'($urandom)});
    if (lace_plan.size() > 0) pkt_open = (lace_plan[lace_plan.size() - 1] == LaceFull);
    page_cnt++;
  endtask

  // Well-formed random page: zeros only where they close a full segment,
  // packets kept within MaxPkt.
  task automatic plan_random(output logic eos);
    int nseg;
    int lace;
    int prev;
    int r;
    int run;
    lace_plan.delete();
    r = $urandom_range(99);
    if (r < 5) nseg = 0;
    else if (r < 8) nseg = 255;
    else nseg = $urandom_range(5, 1);
    prev = pkt_open ? 255 : 1;
    run  = open_len;
    for (int i = 0; i < nseg; i++) begin
      r = $urandom_range(99);
      if (prev == 255 && r < 25) lace = 0;
      else if (nseg == 255) lace = $urandom_range(2, 1);
      else if (r < 83) lace = $urandom_range(6, 1);
      else if (r < 92) lace = 255;
      else lace = $urandom_range(254, 7);
      if (run + lace > MaxPkt) lace = $urandom_range(MaxPkt - run, 1);
      run = (lace == 255) ? run + lace : 0;
      lace_plan.push_back(lace);
      prev = lace;
    end
    // EOS only where it cannot end the run: empty page or packet left open
    if (nseg == 0) eos = 1'($urandom_range(1));
    else if (lace_plan[nseg - 1] == 255) eos = 1'($urandom_range(1));
    else eos = 1'b0;
  endtask

  initial begin
    int    hold_left;
    hold_left       = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (cyc == HoldAt) hold_left = HoldLen;
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready_i <= !idle_now();
      end
    end
  end

  initial begin
    wait (cyc >= CycleLimit);
    $display("Run timed out after %0d cycles with %0d results outstanding.", cyc, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic  took;
    logic  eos;
    int    sent;
    int    mark;
    int    ending;
    string ending_name;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = 8'h00;
    s_axis_tuser_i  = 1'b0;
    pkt_open        = 1'b0;
    open_len        = 0;
    page_cnt        = 0;

    // empty page with the EOS flag: no effect
    lace_plan.delete();
    put_page(1'b1, -1);
    // shortest packet, full segment closed by a zero, longest short segment,
    // then a packet left open across an EOS page
    lace_plan = '{1, 255, 0, 254, 255};
    put_page(1'b1, -1);
    // empty page while the packet is open
    lace_plan.delete();
    put_page(1'b0, -1);
    // leading zero closes the open packet from the lacing table alone
    lace_plan = '{0, 3};
    put_page(1'b0, -1);

    ending = $urandom_range(EndTrunc, EndDone);
    while (byte_q.size() < ItemCount - ((ending == EndLarge) ? LargeBytes : 0)) begin
      plan_random(eos);
      put_page(eos, -1);
    end

    case (ending)
      EndDone: begin
        ending_name = "end-of-stream packet";
        lace_plan.delete();
        if (pkt_open && $urandom_range(1)) lace_plan.push_back(0);
        else repeat ($urandom_range(4, 1))
          lace_plan.push_back($urandom_range(pkt_open ? 40 : 254, 1));
        put_page(1'b1, -1);
      end
      EndCapture: begin
        ending_name = "bad capture pattern";
        lace_plan = '{5};
        put_page(1'b0, $urandom_range(3));
      end
      EndZero: begin
        ending_name = "zero-length packet";
        lace_plan.delete();
        if (!pkt_open && $urandom_range(1)) begin
          lace_plan.push_back(0);
        end else begin
          lace_plan.push_back($urandom_range(20, 1));
          lace_plan.push_back(0);
        end
        put_page(1'b0, -1);
      end
      EndLarge: begin
        ending_name = "oversized packet";
        lace_plan = '{255, 255};
        put_page(1'b0, -1);
      end
      default: begin
        ending_name = "truncated input";
        mark = byte_q.size();
        plan_random(eos);
        put_page(eos, -1);
        byte_q.insert($urandom_range(byte_q.size() - 1, mark), 9'h100);
      end
    endcase
    // noise after the halt, end-of-input flag included
    repeat (16) byte_q.push_back(9'($urandom));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    sent = 0;
    while (sent < byte_q.size()) begin
      @(posedge clk_i);
      took = s_axis_tvalid_i && s_axis_tready_o;
      if (took) sent++;
      if (sent == byte_q.size()) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (took || !s_axis_tvalid_i) begin
        if (idle_now()) begin
          s_axis_tvalid_i <= 1'b0;
        end else begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= byte_q[sent][7:0];
          s_axis_tuser_i  <= byte_q[sent][8];
        end
      end
    end

    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Streamed %0d bytes in %0d pages, run ended on %s.",
             byte_q.size(), page_cnt, ending_name);
    $display("Compared %0d results, %0d of them closing a packet.", checked, packets);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
